### hdl/fault_rule_match_table_top_macros.svh
// Assertion macros for the fault rule match table.
// Used by fault_rule_match_table_top; expects clk and rst_n in scope.
`ifndef FAULT_RULE_MATCH_TABLE_TOP_MACROS_SVH
`define FAULT_RULE_MATCH_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FRMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FRMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FRMT_ASSERT_IMPL(lbl, ante, cons, msg)
`define FRMT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/frmt_pkg.sv
// Shared types and codes of the fault rule match table.
// No dependencies.
package frmt_pkg;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_GET  = 2'd2;
  localparam logic [1:0] KIND_FIND = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;
  localparam logic [1:0] ST_NOENT = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rule_index;
    logic [63:0] new_start;
    logic [63:0] new_end;
    logic [7:0]  new_flags;
    logic [31:0] new_skip;
    logic [31:0] new_life;
    logic [2:0]  new_hooks;
    logic [63:0] access_pos;
    logic [31:0] access_len;
    logic [7:0]  access_flags;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  rule_id;
    logic [63:0] read_start;
    logic [63:0] read_end;
    logic [7:0]  read_flags;
    logic [31:0] read_skip;
    logic [31:0] read_life;
    logic [2:0]  read_hooks;
    logic [2:0]  hook_union;
    logic [15:0] match_map;
  } out_item_t;

  typedef struct packed {
    logic [63:0] rng_start;
    logic [63:0] rng_end;
    logic [7:0]  flags;
    logic [31:0] skip;
    logic [31:0] life;
    logic [2:0]  hooks;
  } rule_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_FIN} fsm_t;

endpackage

### hdl/frmt_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on frmt_pkg.
interface frmt_in_if import frmt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface frmt_out_if import frmt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/frmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/fault_rule_match_table_top.sv
// Fault rule match table: top level with request sequencer and rule RAM.
// Depends on frmt_pkg, frmt_if, frmt_ram and the assertion macro header.
//
// Usage: requests arrive on in_ch (valid/ready), one result per request
// leaves on out_ch (valid/ready). A transaction moves on valid & ready.
// Add, delete and failed get/delete answer from the accepting cycle: the
// result is registered and valid in the cycle after acceptance. A
// successful get reads the rule RAM and answers through S_READ and
// S_FIN. Find walks every slot through the rule RAM, one slot per cycle
// with read and write-back overlapped, then answers; that walk sets the
// rate. One request is in work at a time; the next is taken once the
// block is idle and the output register is empty or being drained, so
// add/delete leave the block idle; get/find hold it until S_FIN ends.
// Reset clears all active bits at once; rule contents are not cleared
// and no clearing pass runs. When out_ch stalls, the result holds in the
// output register and a finished get/find waits before writing it.
`include "fault_rule_match_table_top_macros.svh"
module fault_rule_match_table_top import frmt_pkg::*; #(
  parameter int RULE_SLOTS = 16
) (
  input logic        clk,
  input logic        rst_n,
  frmt_in_if.sink    in_ch,
  frmt_out_if.source out_ch
);

  localparam int IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CW = $clog2(RULE_SLOTS + 1);
  localparam logic [CW-1:0] LAST = CW'(RULE_SLOTS);

  fsm_t state_r, state_nxt;
  logic [RULE_SLOTS-1:0] active_r, active_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t res_r, res_nxt;
  out_item_t imm_res;
  logic [63:0] stop_r, pos_r;
  logic [7:0]  afl_r;
  logic [CW-1:0] scan_cnt_r;
  logic          eval_v_r;
  logic [IW-1:0] eval_idx_r;

  logic          in_fire, out_free, in_ready;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW:0]   slot_num;
  logic          idx_ok, slot_live;
  logic [IW-1:0] sel;
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  rule_t         ram_wdata, rd, wb, new_rule;
  logic          range_hit, trig, die, scanning;
  logic          imm_load;

  frmt_ram #(.WIDTH($bits(rule_t)), .DEPTH(RULE_SLOTS)) u_rule_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ready;
  assign scanning = (state_r == S_SCAN) && (scan_cnt_r < LAST);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign slot_num = {1'b0, free_idx} + (IW+1)'(1);
  assign idx_ok   = (in_ch.data.rule_index != 8'd0) &&
                    (in_ch.data.rule_index <= 8'(RULE_SLOTS));
  assign sel       = IW'(in_ch.data.rule_index - 8'd1);
  assign slot_live = active_r[sel];

  always_comb begin
    new_rule.rng_start = in_ch.data.new_start;
    new_rule.rng_end   = in_ch.data.new_end;
    new_rule.flags     = in_ch.data.new_flags;
    new_rule.skip      = in_ch.data.new_skip;
    new_rule.life      = in_ch.data.new_life;
    new_rule.hooks     = in_ch.data.new_hooks;
  end

  // match test on the slot read last cycle
  always_comb begin
    range_hit = eval_v_r && active_r[eval_idx_r] && (rd.rng_start < stop_r) &&
                ((rd.rng_end == 64'd0) || (rd.rng_end > pos_r)) &&
                ((rd.flags & afl_r) != 8'd0);
    trig = range_hit && (rd.skip == 32'd0);
    die  = trig && (rd.life == 32'd1);
    wb   = rd;
    if (rd.skip != 32'd0) begin
      wb.skip = rd.skip - 32'd1;
    end
    if (trig && (rd.life != 32'd0)) begin
      wb.life = rd.life - 32'd1;
    end
  end

  // answer for requests settled in the accepting cycle
  always_comb begin
    imm_res = '0;
    imm_load = 1'b0;
    case (in_ch.data.kind)
      KIND_ADD: begin
        imm_load = 1'b1;
        if (free_found) begin
          imm_res.status  = ST_OK;
          imm_res.rule_id = 5'(slot_num);
        end else begin
          imm_res.status = ST_NOMEM;
        end
      end
      KIND_DEL, KIND_GET: begin
        if (!idx_ok) begin
          imm_load = 1'b1;
          imm_res.status = ST_INVAL;
        end else if (!slot_live) begin
          imm_load = 1'b1;
          imm_res.status = ST_NOENT;
        end else begin
          imm_load = (in_ch.data.kind == KIND_DEL);
          imm_res.status = ST_OK;
        end
      end
      default: begin
        imm_load = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.kind == KIND_FIND) begin
            state_nxt = S_SCAN;
          end else if (in_ch.data.kind == KIND_GET && idx_ok && slot_live) begin
            state_nxt = S_READ;
          end
        end
      end
      S_SCAN: begin
        if (scan_cnt_r == LAST && !eval_v_r) begin
          state_nxt = S_FIN;
        end
      end
      S_READ: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and RAM ports
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = new_rule;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_fire && in_ch.data.kind == KIND_ADD && free_found) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
        end
        if (in_fire && in_ch.data.kind == KIND_GET && idx_ok && slot_live) begin
          ram_re    = 1'b1;
          ram_raddr = sel;
        end
      end
      S_SCAN: begin
        ram_re    = scanning;
        ram_raddr = scan_cnt_r[IW-1:0];
        if (range_hit) begin
          ram_we    = 1'b1;
          ram_waddr = eval_idx_r;
          ram_wdata = wb;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  // active bits and result accumulation
  always_comb begin
    active_nxt = active_r;
    res_nxt    = res_r;
    if (in_fire) begin
      res_nxt = '0;
      if (in_ch.data.kind == KIND_ADD && free_found) begin
        active_nxt[free_idx] = 1'b1;
      end
      if (in_ch.data.kind == KIND_DEL && idx_ok) begin
        active_nxt[sel] = 1'b0;
      end
    end
    if (state_r == S_SCAN && trig) begin
      res_nxt.hook_union = res_r.hook_union | rd.hooks;
      for (int i = 0; i < 16; i++) begin
        if (i < RULE_SLOTS && int'(eval_idx_r) == i) begin
          res_nxt.match_map[i] = 1'b1;
        end
      end
      if (die) begin
        active_nxt[eval_idx_r] = 1'b0;
      end
    end
    if (state_r == S_READ) begin
      res_nxt.read_start = rd.rng_start;
      res_nxt.read_end   = rd.rng_end;
      res_nxt.read_flags = rd.flags;
      res_nxt.read_skip  = rd.skip;
      res_nxt.read_life  = rd.life;
      res_nxt.read_hooks = rd.hooks;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_fire && imm_load) begin
      out_nxt       = imm_res;
      out_valid_nxt = 1'b1;
    end else if (state_r == S_FIN && out_free) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      eval_v_r    <= 1'b0;
      scan_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      eval_v_r    <= scanning;
      if (in_fire) begin
        scan_cnt_r <= '0;
      end else if (scanning) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    res_r      <= res_nxt;
    eval_idx_r <= scan_cnt_r[IW-1:0];
    if (in_fire) begin
      stop_r <= in_ch.data.access_pos + {32'd0, in_ch.data.access_len};
      pos_r  <= in_ch.data.access_pos;
      afl_r  <= in_ch.data.access_flags;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  `FRMT_ASSERT_IMPL(a_no_rw_clash, (ram_we && ram_re), (ram_waddr != ram_raddr), "RAM read and write hit the same slot")
  `FRMT_ASSERT_IMPL(a_eval_in_scan, eval_v_r, (state_r == S_SCAN), "slot evaluation outside a find walk")
  `FRMT_ASSERT_NEXT(a_add_ok, (in_fire && in_ch.data.kind == KIND_ADD && free_found), (out_valid_r && out_r.status == ST_OK && active_r != '0), "add with free slot did not answer ok")

endmodule
